// ===== hw/rtl/fet_pkg.sv =====
// Package for the FAT entry table engine.
// Holds request, status and layout codes and the controller state type.
// No dependencies.
package fet_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_READ = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_ADDR = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_INVALID = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;

    localparam logic [2:0] CFG_KIND = 3'd0;
    localparam logic [2:0] CFG_TOTAL = 3'd1;
    localparam logic [2:0] CFG_FATSIZE = 3'd2;
    localparam logic [2:0] CFG_DSTART = 3'd3;
    localparam logic [2:0] CFG_BPC = 3'd4;
    localparam logic [2:0] CFG_ROOT = 3'd5;

    localparam logic [31:0] EOC_VALUE = 32'h0fff_ffff;
    localparam logic [31:0] EOC32 = 32'h0fff_fff0;
    localparam logic [15:0] EOC16 = 16'hfff0;
    localparam logic [11:0] EOC12 = 12'hff0;

    // One-hot controller states.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_MUL = 7'b0000100,
        S_ACCESS = 7'b0001000,
        S_WAIT = 7'b0010000,
        S_MERGE = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic check;
        logic mul;
        logic access;
        logic merge;
        logic finish;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic early_done;
        logic last_byte;
        logic need_merge;
    } stat_t;

endpackage

// ===== hw/rtl/fat_entry_table_engine.sv =====
// FAT entry table engine: one request at a time. Load and invalid requests finish
// first, then address and outside-store requests, then writes; reads take longest.
// busy drops the cycle after the result strobe. Results cannot be stalled. Reset
// restores the configuration registers, the controller state and the strobe;
// store undefined. Uses fet_ctrl, fet_datapath.
module fat_entry_table_engine #(
    parameter int STORE_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [27:0] cluster,
    input  logic [31:0] new_value,
    input  logic [1:0]  fat_copy,
    input  logic        is_root,
    input  logic [15:0] load_addr,
    input  logic [7:0]  load_data,
    output logic        done,
    output logic [47:0] result_value,
    output logic        end_of_chain,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import fet_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [1:0]  kind_reg;
    logic [27:0] total_reg;
    logic [24:0] fsize_reg;
    logic [47:0] dstart_reg;
    logic [16:0] bpc_reg;
    logic [20:0] root_reg;
    cmd_t        cmd;
    stat_t       stat;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 2'd2;
            total_reg <= '0;
            fsize_reg <= '0;
            dstart_reg <= '0;
            bpc_reg <= 17'd512;
            root_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KIND: kind_reg <= cfg_data[1:0];
                CFG_TOTAL: total_reg <= cfg_data[27:0];
                CFG_FATSIZE: fsize_reg <= cfg_data[24:0];
                CFG_DSTART: dstart_reg <= cfg_data;
                CFG_BPC: bpc_reg <= cfg_data[16:0];
                CFG_ROOT: root_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    fet_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
    );

    fet_datapath #(.STORE_BYTES(STORE_BYTES), .AW(AW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .req_type(req_type), .cluster(cluster), .new_value(new_value),
        .fat_copy(fat_copy), .is_root(is_root), .load_addr(load_addr),
        .load_data(load_data), .fat_kind(kind_reg), .total_clusters(total_reg),
        .fat_size_bytes(fsize_reg), .data_start(dstart_reg),
        .bytes_per_cluster(bpc_reg), .root_bytes(root_reg),
        .strobe(done), .result_value(result_value),
        .end_of_chain(end_of_chain), .status(status)
    );

endmodule

// ===== hw/rtl/fet_datapath.sv =====
// Datapath of the FAT entry table engine: request registers, byte store,
// address and decode logic. Depends on fet_pkg.
module fet_datapath #(
    parameter int STORE_BYTES = 65536,
    parameter int AW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fet_pkg::cmd_t        cmd,
    output fet_pkg::stat_t       stat,
    input  logic [1:0]           req_type,
    input  logic [27:0]          cluster,
    input  logic [31:0]          new_value,
    input  logic [1:0]           fat_copy,
    input  logic                 is_root,
    input  logic [15:0]          load_addr,
    input  logic [7:0]           load_data,
    input  logic [1:0]           fat_kind,
    input  logic [27:0]          total_clusters,
    input  logic [24:0]          fat_size_bytes,
    input  logic [47:0]          data_start,
    input  logic [16:0]          bytes_per_cluster,
    input  logic [20:0]          root_bytes,
    output logic                 strobe,
    output logic [47:0]          result_value,
    output logic                 end_of_chain,
    output logic [1:0]           status
);
    import fet_pkg::*;

    localparam logic [31:0] LIMIT = 32'(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];

    logic [1:0]  req_reg;
    logic [27:0] clu_reg;
    logic [31:0] nv_reg;
    logic [1:0]  copy_reg;
    logic        root_reg;
    logic [15:0] laddr_reg;
    logic [7:0]  ldata_reg;
    logic [47:0] prod_reg;
    logic [30:0] off_reg;
    logic [1:0]  idx_reg;
    logic        rd_pend_reg;
    logic [7:0]  rdata_reg;
    logic [31:0] acc_reg;
    logic [47:0] val_reg;
    logic        eoc_reg;
    logic [1:0]  st_reg;
    logic        early_reg;
    logic        strobe_reg;

    logic        k12;
    logic        k16;
    logic        wide;
    logic [31:0] idx;
    logic [29:0] half;
    logic [30:0] pos;
    logic [26:0] copy_off;
    logic [1:0]  last_idx;
    logic [AW-1:0] addr;
    logic [7:0]  wbyte;
    logic [31:0] word;

    assign k12 = (fat_kind == KIND_FAT12);
    assign k16 = (fat_kind == KIND_FAT16);
    assign wide = !k12 && !k16;
    assign last_idx = wide ? 2'd3 : 2'd1;

    // Cluster index for the address request.
    always_comb
    begin
        if (wide || !root_reg)
            idx = {4'd0, clu_reg} - 32'd2;
        else
            idx = {4'd0, clu_reg};
    end

    // Byte position of the entry within one FAT copy.
    always_comb
    begin
        if (k12)
            half = ({2'b0, clu_reg} + {3'b0, clu_reg[27:1]});
        else if (k16)
            half = {1'b0, clu_reg, 1'b0};
        else
            half = {clu_reg, 2'b0};
        pos = {1'b0, half};
    end

    // Start of the selected FAT copy.
    assign copy_off = {2'b0, fat_size_bytes} * {25'd0, copy_reg};

    assign addr = AW'(off_reg + 31'(idx_reg));

    // Byte to write for a write request.
    always_comb
    begin
        wbyte = nv_reg[8*idx_reg +: 8];
        if (k12)
        begin
            if (clu_reg[0])
            begin
                if (idx_reg == 2'd0)
                    wbyte = {nv_reg[3:0], rdata_reg[3:0]};
                else
                    wbyte = nv_reg[11:4];
            end
            else if (idx_reg == 2'd1)
                wbyte = {rdata_reg[7:4], nv_reg[11:8]};
        end
    end

    // Merge the byte just read into the little-endian word.
    always_comb
    begin
        word = acc_reg;
        word[8*idx_reg +: 8] = rdata_reg;
    end

    assign stat.early_done = early_reg;
    assign stat.last_byte = (idx_reg == last_idx);
    assign stat.need_merge = (req_reg == REQ_READ) || (k12 && req_reg == REQ_WRITE);

    // Byte store: at most one access per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.access)
        begin
            if (req_reg == REQ_WRITE && !k12)
                mem[addr] <= wbyte;
            else
                rdata_reg <= mem[addr];
        end
        if (cmd.merge && req_reg == REQ_WRITE)
            mem[addr] <= wbyte;
        if (cmd.check && req_reg == REQ_LOAD && {16'd0, laddr_reg} < LIMIT)
            mem[AW'(laddr_reg)] <= ldata_reg;
    end

    // Request capture and arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            clu_reg <= cluster;
            nv_reg <= new_value;
            copy_reg <= fat_copy;
            root_reg <= is_root;
            laddr_reg <= load_addr;
            ldata_reg <= load_data;
            acc_reg <= '0;
            idx_reg <= '0;
        end
        if (cmd.check)
        begin
            // fat_size times copy fits in 27 bits.
            off_reg <= {4'd0, copy_off} + pos;
            prod_reg <= {31'd0, bytes_per_cluster} * {16'd0, idx};
            val_reg <= '0;
            eoc_reg <= 1'b0;
            st_reg <= ST_OK;
            early_reg <= 1'b1;
            unique case (req_reg)
                REQ_LOAD:
                begin
                    if ({16'd0, laddr_reg} >= LIMIT)
                        st_reg <= ST_OUTSIDE;
                end
                REQ_ADDR:
                    early_reg <= 1'b0;
                default:
                begin
                    if (clu_reg >= total_clusters)
                        st_reg <= ST_INVALID;
                    else
                        early_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.mul)
        begin
            if (req_reg == REQ_ADDR)
            begin
                val_reg <= data_start + prod_reg
                    + ((!wide && !root_reg) ? {27'd0, root_bytes} : 48'd0);
                early_reg <= 1'b1;
            end
            else if ({1'b0, off_reg} + (wide ? 32'd4 : 32'd2) > LIMIT)
            begin
                st_reg <= ST_OUTSIDE;
                early_reg <= 1'b1;
            end
        end
        if (cmd.merge)
        begin
            acc_reg <= word;
            idx_reg <= idx_reg + 2'd1;
        end
        else if (cmd.access && req_reg == REQ_WRITE && !k12)
            idx_reg <= idx_reg + 2'd1;
        // The last byte is merged in the same cycle, so decode the full word.
        if (cmd.finish && req_reg == REQ_READ && st_reg == ST_OK && !early_reg)
        begin
            if (wide)
            begin
                eoc_reg <= ({4'd0, word[27:0]} >= EOC32);
                val_reg <= {20'd0, word[27:0]};
            end
            else if (k16)
            begin
                eoc_reg <= (word[15:0] >= EOC16);
                val_reg <= {32'd0, word[15:0]};
            end
            else
            begin
                eoc_reg <= ((clu_reg[0] ? word[15:4] : word[11:0]) >= EOC12);
                val_reg <= {36'd0, clu_reg[0] ? word[15:4] : word[11:0]};
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.finish;
    end

    assign strobe = strobe_reg;
    assign end_of_chain = eoc_reg && strobe_reg;
    assign result_value = eoc_reg ? {16'd0, EOC_VALUE} : val_reg;
    assign status = st_reg;

endmodule

// ===== hw/rtl/fet_ctrl.sv =====
// Controller of the FAT entry table engine: sequences checks and byte
// accesses. Depends on fet_pkg.
module fet_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fet_pkg::stat_t stat,
    output fet_pkg::cmd_t  cmd,
    output logic           busy
);
    import fet_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (stat.early_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul = 1'b1;
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                if (stat.early_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.access = 1'b1;
                    if (stat.need_merge)
                        state_next = S_WAIT;
                    else if (stat.last_byte)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WAIT:
                state_next = S_MERGE;
            S_MERGE:
            begin
                cmd.merge = 1'b1;
                if (stat.last_byte)
                    state_next = S_DONE;
                else
                    state_next = S_ACCESS;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // Finish when the byte loop completes.
        if (state_reg == S_MERGE && stat.last_byte)
            cmd.finish = 1'b1;
        if (state_reg == S_ACCESS && !stat.early_done && !stat.need_merge && stat.last_byte)
            cmd.finish = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hw/rtl/fet_checker.sv =====
// Port checker for the FAT entry table engine, bound to the top level.
// Depends on the top-level port list only.
module fet_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        end_of_chain,
    input logic [1:0]  status,
    input logic [47:0] result_value
);
    // A request makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    // A result comes only while busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result while idle");
    // A result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held");
    // End of chain only on a successful result carrying the marker.
    a_eoc: assert property (@(posedge clk) disable iff (!rst_n)
        done && end_of_chain |-> status == 2'd0 && result_value == 48'h0fffffff)
        else $error("bad end of chain");
endmodule

bind fat_entry_table_engine fet_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .end_of_chain(end_of_chain), .status(status), .result_value(result_value)
);
